[rtl/core/assert_macros.svh]
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that a condition never occurs outside reset.
`define ASR_NEVER(label, cond, msg) \
  `ASR_ASSERT(label, !(cond), msg)

`endif

[rtl/core/asr_pkg.sv]
// Package: constants and types of the audio stutter repeat block.
package asr_pkg;

  localparam int MaxRecordFrames = 65536;
  localparam int SampleBits      = 24;
  localparam int OutBits         = SampleBits - 1;
  localparam int FrameBits       = 2 * SampleBits;
  localparam int AddrBits        = $clog2(MaxRecordFrames);
  localparam int RecLenBits      = 17;
  localparam int LenBits         = 24;
  localparam int PosBits         = LenBits + 1;
  localparam int CfgIdxBits      = 2;
  localparam int CfgDataBits     = 24;

  localparam logic [RecLenBits-1:0] MaxRecLen = RecLenBits'(MaxRecordFrames);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgStartDelay = 2'd0,
    CfgRecordLen  = 2'd1,
    CfgTotalLen   = 2'd2
  } cfg_reg_e;

endpackage

[rtl/core/asr_ram.sv]
// Generic single-port RAM with registered read data.
module asr_ram #(
  parameter int Width = 48,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/audio_stutter_repeat.sv]
// Audio stutter (beat repeat) effect: top level with control and output stage.
//
// Takes one stereo frame per clock cycle while the output is not stalled and gives
// its result in the cycle after the frame is taken. Each frame is either recorded
// into or replayed from a single-port repeat RAM of 65536 stereo entries, so one
// RAM access per frame sets the one-frame-per-cycle rate. The start delay, record
// length and total length registers are written through the configuration channel;
// the user must write them only while no frame is in flight; the block does not
// enforce it. Record lengths of zero act as one, above the RAM depth as the depth.
`include "assert_macros.svh"

module audio_stutter_repeat (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               arm_i,
  input  logic signed [asr_pkg::SampleBits-1:0] left_in_i,
  input  logic signed [asr_pkg::SampleBits-1:0] right_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [asr_pkg::OutBits-1:0] left_out_o,
  output logic signed [asr_pkg::OutBits-1:0] right_out_o,
  output logic                               effect_busy_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [asr_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [asr_pkg::CfgDataBits-1:0]    cfg_data_i
);
  import asr_pkg::*;

  logic [LenBits-1:0]    start_delay_q, total_len_q;
  logic [RecLenBits-1:0] record_len_q;

  logic                       active_q, active_d;
  logic signed [PosBits-1:0]  pos_q, pos_d, pos0;
  logic [AddrBits-1:0]        ridx_q, ridx_d, ridx0;
  logic [RecLenBits-1:0]      rl;
  logic [RecLenBits-1:0]      ridx_inc;
  logic                       active0;
  logic                       do_rec, do_play;
  logic                       in_acc;

  logic                       s1_valid_q;
  logic                       s1_mem_q;
  logic                       s1_busy_q;
  logic [SampleBits-1:0]      s1_left_q, s1_right_q;
  logic [FrameBits-1:0]       ram_rdata;
  logic [SampleBits-1:0]      sel_left, sel_right;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= '0;
      record_len_q  <= RecLenBits'(1);
      total_len_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgStartDelay: start_delay_q <= cfg_data_i[LenBits-1:0];
        CfgRecordLen:  record_len_q  <= cfg_data_i[RecLenBits-1:0];
        CfgTotalLen:   total_len_q   <= cfg_data_i[LenBits-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_stall_o = s1_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Per-frame control
  always_comb begin
    if (record_len_q == '0) begin
      rl = RecLenBits'(1);
    end else if (record_len_q > MaxRecLen) begin
      rl = MaxRecLen;
    end else begin
      rl = record_len_q;
    end
  end

  always_comb begin
    active0  = active_q;
    pos0     = pos_q;
    if (arm_i && !active_q) begin
      active0 = 1'b1;
      pos0    = -$signed({1'b0, start_delay_q});
    end

    do_rec   = 1'b0;
    do_play  = 1'b0;
    active_d = active0;
    pos_d    = pos0;
    ridx_d   = ridx_q;
    ridx0    = ridx_q;
    ridx_inc = '0;

    if (active0) begin
      if (pos0[PosBits-1]) begin
        pos_d = pos0 + PosBits'(1);
      end else if ($unsigned(pos0) < PosBits'(rl)) begin
        do_rec = 1'b1;
        pos_d  = pos0 + PosBits'(1);
        ridx_d = '0;
      end else if ($unsigned(pos0) < PosBits'(total_len_q)) begin
        do_play = 1'b1;
        if (RecLenBits'(ridx_q) >= rl) begin
          ridx0 = '0;
        end
        ridx_inc = RecLenBits'(ridx0) + RecLenBits'(1);
        if (ridx_inc >= rl) begin
          ridx_d = '0;
        end else begin
          ridx_d = ridx_inc[AddrBits-1:0];
        end
        pos_d = pos0 + PosBits'(1);
      end
      if (!pos_d[PosBits-1] && $unsigned(pos_d) >= PosBits'(total_len_q)) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      ridx_q   <= '0;
    end else if (in_acc) begin
      active_q <= active_d;
      pos_q    <= pos_d;
      ridx_q   <= ridx_d;
    end
  end

  // Repeat memory: record writes at the frame position, replay reads the ring index
  asr_ram #(
    .Width (FrameBits),
    .Depth (MaxRecordFrames)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (in_acc && (do_rec || do_play)),
    .we_i    (do_rec),
    .addr_i  (do_rec ? pos0[AddrBits-1:0] : ridx0),
    .wdata_i ({left_in_i, right_in_i}),
    .rdata_o (ram_rdata)
  );

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mem_q   <= do_play;
      s1_busy_q  <= active_d;
      s1_left_q  <= left_in_i;
      s1_right_q <= right_in_i;
    end
  end

  assign sel_left  = s1_mem_q ? ram_rdata[FrameBits-1:SampleBits] : s1_left_q;
  assign sel_right = s1_mem_q ? ram_rdata[SampleBits-1:0] : s1_right_q;

  assign out_valid_o   = s1_valid_q;
  assign left_out_o    = sel_left[SampleBits-1:1];
  assign right_out_o   = sel_right[SampleBits-1:1];
  assign effect_busy_o = s1_busy_q;

  // Checks
  `ASR_ASSERT(a_rec_adv, (in_acc && do_rec) |=> (!pos_q[PosBits-1] && pos_q != '0),
              "frame position did not advance past a recorded frame")
  `ASR_ASSERT(a_play_out, (in_acc && do_play) |=> (s1_valid_q && s1_mem_q),
              "replayed frame not selected at the output")
  `ASR_NEVER(a_rec_play, do_rec && do_play, "record and replay in the same frame")

endmodule

[tb/sv/tb_audio_stutter_repeat.sv]
// Self-checking testbench for the audio stutter repeat block: directed and random frames.
`timescale 1ns / 100ps

module tb_audio_stutter_repeat;
  import asr_pkg::*;

  localparam int MaxLen = (1 << LenBits) - 1;
  localparam int RecLenFieldMax = (1 << RecLenBits) - 1;
  localparam logic [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [SampleBits-1:0] SampleOne = SampleBits'(1);

  typedef struct packed {
    logic                  arm;
    logic [SampleBits-1:0] left;
    logic [SampleBits-1:0] right;
  } frame_t;

  typedef struct packed {
    logic [OutBits-1:0] left;
    logic [OutBits-1:0] right;
    logic               busy;
  } stutter_out_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         arm_i = 1'b0;
  logic signed [SampleBits-1:0] left_in_i = '0;
  logic signed [SampleBits-1:0] right_in_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [OutBits-1:0]    left_out_o;
  logic signed [OutBits-1:0]    right_out_o;
  logic                         effect_busy_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CfgIdxBits-1:0]        cfg_index_i = '0;
  logic [CfgDataBits-1:0]       cfg_data_i = '0;

  audio_stutter_repeat uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .arm_i        (arm_i),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o),
    .effect_busy_o(effect_busy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Stutter state mirror and its register copies, at their reset values.
  bit                   fx_active = 1'b0;
  int                   fx_pos = 0;
  int                   fx_replay = 0;
  logic [FrameBits-1:0] fx_mem [MaxRecordFrames];
  int                   delay_reg = 0;
  int                   reclen_reg = 1;
  int                   total_reg = 0;

  frame_t       pending_q[$];
  stutter_out_t expected_q[$];
  frame_t       drv_frame;
  stutter_out_t exp_o;
  stutter_out_t got_o;
  logic         in_fire = 1'b0;
  int           in_idle_pct = 0;
  int           out_idle_pct = 0;
  int           queued = 0;
  int           accepted = 0;
  int           checked = 0;
  int           errors = 0;
  int           arms_taken = 0;
  int           replays = 0;
  int           cfg_writes = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_rec_len(int n);
    if (n == 0) return 1;
    if (n > MaxRecordFrames) return MaxRecordFrames;
    return n;
  endfunction

  function automatic stutter_out_t stutter_predict(frame_t f);
    int                    rl;
    logic [SampleBits-1:0] l;
    logic [SampleBits-1:0] r;
    stutter_out_t          o;
    rl = clamp_rec_len(reclen_reg);
    l = f.left;
    r = f.right;
    if (f.arm && !fx_active) begin
      fx_active = 1'b1;
      fx_pos = -delay_reg;
      arms_taken++;
    end
    if (fx_active) begin
      if (fx_pos < 0) begin
        fx_pos++;
      end else if (fx_pos < rl) begin
        fx_mem[fx_pos[AddrBits-1:0]] = {l, r};
        fx_pos++;
        fx_replay = 0;
      end else if (fx_pos < total_reg) begin
        if (fx_replay >= rl) fx_replay = 0;
        {l, r} = fx_mem[fx_replay[AddrBits-1:0]];
        fx_replay++;
        if (fx_replay >= rl) fx_replay = 0;
        fx_pos++;
        replays++;
      end
      if (fx_pos >= 0 && fx_pos >= total_reg) fx_active = 1'b0;
    end
    o.left = l[SampleBits-1:1];
    o.right = r[SampleBits-1:1];
    o.busy = fx_active;
    return o;
  endfunction

  task automatic cfg_write(cfg_reg_e idx, int d);
    logic [CfgDataBits-1:0] dv;
    dv = CfgDataBits'(d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= dv;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgStartDelay: delay_reg = int'(dv);
      CfgRecordLen:  reclen_reg = int'(dv[RecLenBits-1:0]);
      CfgTotalLen:   total_reg = int'(dv);
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_frame(logic arm, logic [SampleBits-1:0] l, logic [SampleBits-1:0] r);
    pending_q.push_back({arm, l, r});
    queued++;
  endtask

  task automatic drain();
    while (accepted != queued || expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SampleBits-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SampleMax;
      1: return SampleMin;
      2: return '1;
      3: return '0;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  // Record length may only grow while idle so replay never reads unwritten entries.
  task automatic random_phase(int n);
    int                     rl;
    logic [CfgDataBits-1:0] d;
    if ($urandom_range(2) != 0)
      cfg_write(CfgStartDelay, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8));
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(9))
        0: rl = 0;
        1: rl = MaxRecordFrames;
        2: rl = RecLenFieldMax;
        default: rl = $urandom_range(1, 12);
      endcase
      d = CfgDataBits'($urandom);
      d[RecLenBits-1:0] = RecLenBits'(rl);
      if (!fx_active || clamp_rec_len(rl) <= clamp_rec_len(reclen_reg))
        cfg_write(CfgRecordLen, int'(d));
    end
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(7))
        0: cfg_write(CfgTotalLen, 0);
        1: cfg_write(CfgTotalLen, MaxLen);
        default: cfg_write(CfgTotalLen, $urandom_range(0, 40));
      endcase
    end
    for (int i = 0; i < n; i++)
      add_frame(i == 0 || $urandom_range(15) == 0, rand_sample(), rand_sample());
    drain();
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
    if (!in_valid_i || in_fire) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        drv_frame = pending_q.pop_front();
        arm_i <= drv_frame.arm;
        left_in_i <= drv_frame.left;
        right_in_i <= drv_frame.right;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_q.push_back(stutter_predict({arm_i, left_in_i, right_in_i}));
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_o = {left_out_o, right_out_o, effect_busy_o};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: L=%0d R=%0d busy=%0b",
                   left_out_o, right_out_o, effect_busy_o);
      end else begin
        exp_o = expected_q.pop_front();
        checked++;
        if (got_o.left !== exp_o.left || got_o.right !== exp_o.right ||
            got_o.busy !== exp_o.busy) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected L=%0d R=%0d busy=%0b, got L=%0d R=%0d busy=%0b",
                     checked, $signed(exp_o.left), $signed(exp_o.right), exp_o.busy,
                     left_out_o, right_out_o, effect_busy_o);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    in_idle_pct = 29;
    out_idle_pct = 81;

    // delay, zero record length acting as one, replay of that single frame
    cfg_write(CfgStartDelay, 2);
    cfg_write(CfgRecordLen, 0);
    cfg_write(CfgTotalLen, 4);
    add_frame(1'b1, SampleMax, SampleMin);
    add_frame(1'b0, SampleMin, SampleMax);
    add_frame(1'b0, '0, '1);
    add_frame(1'b0, '1, '0);
    add_frame(1'b0, SampleOne, SampleMax);
    add_frame(1'b0, SampleMax, SampleMax);
    add_frame(1'b0, SampleMin, SampleMin);
    drain();
    // oversized record length, recording cut short by total length
    cfg_write(CfgStartDelay, 0);
    cfg_write(CfgRecordLen, '1);
    cfg_write(CfgTotalLen, 3);
    add_frame(1'b1, SampleOne, '1);
    add_frame(1'b0, SampleMax, '0);
    add_frame(1'b0, '1, SampleMin);
    add_frame(1'b0, '0, SampleOne);
    drain();
    // zero total length: effect ends as the delay runs out
    cfg_write(CfgStartDelay, 3);
    cfg_write(CfgTotalLen, 0);
    add_frame(1'b1, SampleMin, SampleOne);
    add_frame(1'b0, SampleOne, SampleMin);
    add_frame(1'b0, SampleMax, '1);
    add_frame(1'b0, '1, SampleMax);
    drain();
    // endless replay with wrap, arm ignored while active, then cut off
    cfg_write(CfgStartDelay, 0);
    cfg_write(CfgRecordLen, 3);
    cfg_write(CfgTotalLen, MaxLen);
    add_frame(1'b1, SampleMax, SampleOne);
    add_frame(1'b0, SampleMin, '1);
    add_frame(1'b0, '1, SampleMax);
    for (int i = 0; i < 5; i++) add_frame(i == 2, rand_sample(), rand_sample());
    drain();
    cfg_write(CfgTotalLen, 0);
    add_frame(1'b0, SampleOne, SampleMin);
    add_frame(1'b1, SampleMin, '0);
    drain();

    for (int p = 0; p < 19; p++) begin
      if (p == 6) begin
        in_idle_pct = 81;
        out_idle_pct = 29;
      end else if (p == 13) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      random_phase(50);
    end

    // maximum start delay: the effect stays in its delay until the end
    cfg_write(CfgTotalLen, 0);
    for (int i = 0; i < 12; i++) add_frame(1'b0, rand_sample(), rand_sample());
    drain();
    cfg_write(CfgStartDelay, MaxLen);
    for (int i = 0; i < 10; i++) add_frame(1'b1, rand_sample(), rand_sample());
    drain();

    repeat (4) @(posedge clk_i);
    $display("Run: %0d frames, %0d results checked, %0d effect starts, %0d replayed frames.",
             accepted, checked, arms_taken, replays);
    $display("%0d register writes across phases; %0d mismatches.", cfg_writes, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
